/* src/aoqt_pkg.sv */
// shared types and constants for the box overlap query table
// no dependencies; imported by the entry stage, the cell and the top level
`timescale 1ns / 1ps
`default_nettype none

package aoqt_pkg;

  localparam int SLOT_W = 6;
  localparam int REQ_W  = 2;

  // request codes as carried on req_type
  typedef enum logic [REQ_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_SEG   = 2'd1,
    OP_POINT = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // control that travels with a request down the row of cells
  typedef struct packed {
    logic              valid;
    op_t               op;
    logic [SLOT_W-1:0] slot;
    logic              is_box;
    logic              skip_en;
    logic [SLOT_W-1:0] skip_slot;
    logic              hit;
  } ctrl_t;

endpackage

`default_nettype wire

/* src/aoqt_front.sv */
// entry stage: decodes a request and forms the doubled bounds for the cells
// depends on aoqt_pkg
`timescale 1ns / 1ps
`default_nettype none

module aoqt_front #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          adv,
  input  wire logic                          in_valid,
  input  wire logic [1:0]                    req_type,
  input  wire logic [5:0]                    slot,
  input  wire logic [47:0]                   box_center,
  input  wire logic [47:0]                   box_size,
  input  wire logic                          is_box,
  input  wire logic [47:0]                   end_a,
  input  wire logic [47:0]                   end_b,
  input  wire logic                          skip_enable,
  input  wire logic [5:0]                    skip_slot,
  output aoqt_pkg::ctrl_t                    ctrl_out,
  output logic      [3*(COORD_BITS+2)-1:0]   lo_out,
  output logic      [3*(COORD_BITS+2)-1:0]   hi_out
);
  import aoqt_pkg::*;

  localparam int VW = COORD_BITS + 2;

  op_t                 op;
  ctrl_t               ctrl_next;
  logic [3*VW-1:0]     lo_next;
  logic [3*VW-1:0]     hi_next;
  logic signed [VW-1:0] c2 [3];
  logic signed [VW-1:0] sz [3];
  logic signed [VW-1:0] pa [3];
  logic signed [VW-1:0] pb [3];

  assign op = op_t'(req_type);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      c2[a] = VW'($signed(box_center[a*COORD_BITS +: COORD_BITS])) <<< 1;
      pa[a] = VW'($signed(end_a[a*COORD_BITS +: COORD_BITS])) <<< 1;
      pb[a] = VW'($signed(end_b[a*COORD_BITS +: COORD_BITS])) <<< 1;
    end
    // x takes size word 1, y size word 0, z size word 2
    sz[0] = $signed(VW'(box_size[1*COORD_BITS +: COORD_BITS]));
    sz[1] = $signed(VW'(box_size[0*COORD_BITS +: COORD_BITS]));
    sz[2] = $signed(VW'(box_size[2*COORD_BITS +: COORD_BITS]));
  end

  always_comb begin
    ctrl_next.valid     = in_valid;
    ctrl_next.op        = op;
    ctrl_next.slot      = slot;
    ctrl_next.is_box    = is_box;
    ctrl_next.skip_en   = 1'b0;
    ctrl_next.skip_slot = skip_slot;
    ctrl_next.hit       = 1'b0;
    lo_next = '0;
    hi_next = '0;
    unique case (op)
      OP_LOAD: begin
        for (int a = 0; a < 3; a++) begin
          lo_next[a*VW +: VW] = c2[a] - sz[a];
          hi_next[a*VW +: VW] = c2[a] + sz[a];
        end
      end
      OP_SEG: begin
        ctrl_next.skip_en = skip_enable;
        for (int a = 0; a < 3; a++) begin
          lo_next[a*VW +: VW] = (pa[a] < pb[a]) ? pa[a] : pb[a];
          hi_next[a*VW +: VW] = (pa[a] < pb[a]) ? pb[a] : pa[a];
        end
      end
      OP_POINT: begin
        // a point is a degenerate box: same overlap test in every cell
        for (int a = 0; a < 3; a++) begin
          lo_next[a*VW +: VW] = pa[a];
          hi_next[a*VW +: VW] = pa[a];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else if (adv) begin
      ctrl_out <= ctrl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lo_out <= lo_next;
      hi_out <= hi_next;
    end
  end

endmodule

`default_nettype wire

/* src/aoqt_cell.sv */
// one table slot: holds its corners and flags, tests passing queries
// depends on aoqt_pkg
`timescale 1ns / 1ps
`default_nettype none

module aoqt_cell #(
  parameter int COORD_BITS = 16,
  parameter int IDX        = 0
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          adv,
  input  wire aoqt_pkg::ctrl_t               ctrl_in,
  input  wire logic [3*(COORD_BITS+2)-1:0]   lo_in,
  input  wire logic [3*(COORD_BITS+2)-1:0]   hi_in,
  output aoqt_pkg::ctrl_t                    ctrl_out,
  output logic      [3*(COORD_BITS+2)-1:0]   lo_out,
  output logic      [3*(COORD_BITS+2)-1:0]   hi_out
);
  import aoqt_pkg::*;

  localparam int VW = COORD_BITS + 2;

  logic [3*VW-1:0] box_low;
  logic [3*VW-1:0] box_high;
  logic            used;
  logic            box_flag;
  logic            is_query;
  logic            skipped;
  logic            axes_ok;
  logic            hit_here;
  logic            load_here;
  ctrl_t           ctrl_next;

  assign is_query  = (ctrl_in.op == OP_SEG) || (ctrl_in.op == OP_POINT);
  assign skipped   = ctrl_in.skip_en && (int'(ctrl_in.skip_slot) == IDX);
  assign load_here = adv && ctrl_in.valid && (ctrl_in.op == OP_LOAD) &&
                     (int'(ctrl_in.slot) == IDX);

  always_comb begin
    axes_ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (!(($signed(box_low[a*VW +: VW]) <= $signed(hi_in[a*VW +: VW])) &&
            ($signed(box_high[a*VW +: VW]) >= $signed(lo_in[a*VW +: VW])))) begin
        axes_ok = 1'b0;
      end
    end
  end

  assign hit_here = ctrl_in.valid && is_query && used && box_flag && !skipped && axes_ok;

  always_comb begin
    ctrl_next     = ctrl_in;
    ctrl_next.hit = ctrl_in.hit | hit_here;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= 1'b0;
      box_flag <= 1'b0;
      ctrl_out <= '0;
    end else begin
      if (load_here) begin
        used     <= 1'b1;
        box_flag <= ctrl_in.is_box;
      end
      if (adv) begin
        ctrl_out <= ctrl_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_here) begin
      box_low  <= lo_in;
      box_high <= hi_in;
    end
    if (adv) begin
      lo_out <= lo_in;
      hi_out <= hi_in;
    end
  end

endmodule

`default_nettype wire

/* src/aabb_overlap_query_table.sv */
// top level of the box overlap query table: entry stage and a row of slot cells
// depends on aoqt_pkg, aoqt_front, aoqt_cell
//
// usage:
//   requests arrive on in_valid/in_ready with req_type and its fields; each
//   request gives exactly one response on out_valid/out_ready carrying hit.
//   a load writes one slot and answers hit = 0; a segment or point query
//   answers 1 if some loaded box slot, other than skip_slot when a segment sets skip_enable, overlaps it.
//   the request passes the entry stage register and then one cell register per
//   slot; out_valid and hit come from the register of the last cell.
//   the row is a pipeline: with the receiver ready a new request is taken
//   every cycle, before earlier requests have left the row.
//   loads and queries keep their order, so a query sees every load accepted
//   before it and none accepted after it.
//   when the receiver stalls the whole row holds and in_ready drops in the
//   same cycle; nothing is lost.
//   reset clears the slot flags in every cell at once, so the table starts
//   empty; stored corners are not cleared and are only read once loaded.
`timescale 1ns / 1ps
`default_nettype none

module aabb_overlap_query_table #(
  parameter int NUM_SLOTS  = 64,
  parameter int COORD_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  req_type,
  input  wire logic [5:0]  slot,
  input  wire logic [47:0] box_center,
  input  wire logic [47:0] box_size,
  input  wire logic        is_box,
  input  wire logic [47:0] end_a,
  input  wire logic [47:0] end_b,
  input  wire logic        skip_enable,
  input  wire logic [5:0]  skip_slot,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             hit
);
  import aoqt_pkg::*;

  localparam int VW = COORD_BITS + 2;

  logic            adv;
  ctrl_t           ctrl_chain [NUM_SLOTS+1];
  logic [3*VW-1:0] lo_chain   [NUM_SLOTS];
  logic [3*VW-1:0] hi_chain   [NUM_SLOTS];

  // the last cell's register is the response register
  assign out_valid = ctrl_chain[NUM_SLOTS].valid;
  assign hit       = ctrl_chain[NUM_SLOTS].hit;
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;

  aoqt_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (in_valid),
    .req_type   (req_type),
    .slot       (slot),
    .box_center (box_center),
    .box_size   (box_size),
    .is_box     (is_box),
    .end_a      (end_a),
    .end_b      (end_b),
    .skip_enable(skip_enable),
    .skip_slot  (skip_slot),
    .ctrl_out   (ctrl_chain[0]),
    .lo_out     (lo_chain[0]),
    .hi_out     (hi_chain[0])
  );

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    if (i < NUM_SLOTS - 1) begin : g_mid
      aoqt_cell #(
        .COORD_BITS(COORD_BITS),
        .IDX       (i)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .adv     (adv),
        .ctrl_in (ctrl_chain[i]),
        .lo_in   (lo_chain[i]),
        .hi_in   (hi_chain[i]),
        .ctrl_out(ctrl_chain[i+1]),
        .lo_out  (lo_chain[i+1]),
        .hi_out  (hi_chain[i+1])
      );
    end else begin : g_tail
      // bounds are not needed past the last slot
      aoqt_cell #(
        .COORD_BITS(COORD_BITS),
        .IDX       (i)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .adv     (adv),
        .ctrl_in (ctrl_chain[i]),
        .lo_in   (lo_chain[i]),
        .hi_in   (hi_chain[i]),
        .ctrl_out(ctrl_chain[i+1]),
        .lo_out  (),
        .hi_out  ()
      );
    end
  end

endmodule

`default_nettype wire

/* src/aoqt_checker.sv */
// port-level checks for the box overlap query table, bound to the top level
// depends on aabb_overlap_query_table
`timescale 1ns / 1ps
`default_nettype none

module aoqt_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic hit
);

  // a stalled response holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit))
    else $error("response changed while stalled");

  // the row advances exactly when the response slot is free or taken
  a_ready_link: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow response side");

  // reset empties the row and opens the request side
  a_reset_empty: assert property (@(posedge clk)
    $fell(rst) |-> !out_valid && in_ready)
    else $error("row not empty after reset");

  // a response never carries an unknown hit
  a_hit_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !$isunknown(hit))
    else $error("unknown hit on a response");

endmodule

bind aabb_overlap_query_table aoqt_checker u_aoqt_checker (.*);

`default_nettype wire
